@@ src/rslc_pkg.sv @@
// shared types and constants for the rgb to hsl converter
// no dependencies; every other file imports this package
package rslc_pkg;

	localparam int CH_W            = 8;
	localparam int OUT_W           = 16;
	localparam int SUM_W           = CH_W + 1;
	localparam int HUE_W           = 11;
	localparam int LT_PROD_W       = SUM_W + CH_W;
	localparam int STEP_BITS       = 4;
	localparam int DIV_STAGES      = OUT_W / STEP_BITS;
	localparam int QUEUE_DEPTH_DEF = 4;
	localparam int CH_MAX          = 255;

	typedef enum logic [1:0] {
		MAX_RED,
		MAX_GREEN,
		MAX_BLUE
	} rslc_maxsel_t;

	// one classified pixel waiting for the dividers
	typedef struct packed {
		logic [HUE_W-1:0] hue_num;
		logic [HUE_W-1:0] hue_div;
		logic [CH_W-1:0]  sat_hi;
		logic [OUT_W-1:0] sat_lo;
		logic [CH_W-1:0]  sat_div;
		logic [OUT_W-1:0] lightness;
	} rslc_work_t;

	typedef struct packed {
		logic full;
		logic empty;
	} rslc_qstat_t;

endpackage

@@ src/rslc_pixel_if.sv @@
// input channel: one rgb pixel per transfer
// depends on rslc_pkg
interface rslc_pixel_if
	import rslc_pkg::*;
;
	logic            valid;
	logic            ready;
	logic [CH_W-1:0] red;
	logic [CH_W-1:0] green;
	logic [CH_W-1:0] blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink (input valid, input red, input green, input blue, output ready);
endinterface

@@ src/rslc_hsl_if.sv @@
// output channel: hue, saturation and lightness per transfer
// depends on rslc_pkg
interface rslc_hsl_if
	import rslc_pkg::*;
;
	logic             valid;
	logic             ready;
	logic [OUT_W-1:0] hue;
	logic [OUT_W-1:0] saturation;
	logic [OUT_W-1:0] lightness;

	modport source (output valid, output hue, output saturation, output lightness,
		input ready);
	modport sink (input valid, input hue, input saturation, input lightness,
		output ready);
endinterface

@@ src/rslc_front.sv @@
// front end: takes pixels, finds max/min and builds the divider operands
// depends on rslc_pkg and rslc_pixel_if
module rslc_front
	import rslc_pkg::*;
(
	rslc_pixel_if.sink   pixel,
	input  rslc_qstat_t  qstat,
	output logic         push,
	output rslc_work_t   work
);

	rslc_maxsel_t      sel;
	logic [CH_W-1:0]   mx;
	logic [CH_W-1:0]   mn;
	logic [CH_W-1:0]   d;
	logic [SUM_W-1:0]  sum;
	logic [HUE_W-1:0]  d_w;
	logic [HUE_W-1:0]  six_d;
	logic [HUE_W-1:0]  num;
	logic [CH_W-1:0]   den;
	logic [LT_PROD_W-1:0] lt_prod;

	assign pixel.ready = !qstat.full;
	assign push        = pixel.valid && pixel.ready;

	// red wins ties, then green
	always_comb begin
		if (pixel.red >= pixel.green && pixel.red >= pixel.blue) begin
			sel = MAX_RED;
			mx  = pixel.red;
		end else if (pixel.green >= pixel.blue) begin
			sel = MAX_GREEN;
			mx  = pixel.green;
		end else begin
			sel = MAX_BLUE;
			mx  = pixel.blue;
		end
	end

	always_comb begin
		mn = pixel.red;
		if (pixel.green < mn) begin
			mn = pixel.green;
		end
		if (pixel.blue < mn) begin
			mn = pixel.blue;
		end
	end

	assign d_w   = HUE_W'(d);
	assign six_d = (d_w << 2) + (d_w << 1);

	always_comb begin
		case (sel)
			MAX_RED: begin
				if (pixel.green < pixel.blue) begin
					num = six_d - (HUE_W'(pixel.blue) - HUE_W'(pixel.green));
				end else begin
					num = HUE_W'(pixel.green) - HUE_W'(pixel.blue);
				end
			end
			MAX_GREEN: begin
				num = (d_w << 1) + HUE_W'(pixel.blue) - HUE_W'(pixel.red);
			end
			MAX_BLUE: begin
				num = (d_w << 2) + HUE_W'(pixel.red) - HUE_W'(pixel.green);
			end
			default: begin
				num = '0;
			end
		endcase
	end

	assign d   = mx - mn;
	assign sum = SUM_W'(mx) + SUM_W'(mn);
	assign den = (sum <= SUM_W'(CH_MAX)) ? sum[CH_W-1:0]
		: CH_W'(SUM_W'(2 * CH_MAX) - sum);

	// sum * 65535 / 510 is sum * 257 / 2
	assign lt_prod = {sum, {CH_W{1'b0}}} + LT_PROD_W'(sum);

	// d * 65535 split as (d - 1) * 2^16 + (2^16 - d); grey pixels divide zero by one
	always_comb begin
		work.lightness = lt_prod[OUT_W:1];
		if (d == '0) begin
			work.hue_num = '0;
			work.hue_div = HUE_W'(1);
			work.sat_hi  = '0;
			work.sat_lo  = '0;
			work.sat_div = CH_W'(1);
		end else begin
			work.hue_num = num;
			work.hue_div = six_d;
			work.sat_hi  = d - CH_W'(1);
			work.sat_lo  = OUT_W'(0) - OUT_W'(d);
			work.sat_div = den;
		end
	end

endmodule

@@ src/rslc_queue.sv @@
// short queue between front end and dividers
// depends on rslc_pkg
module rslc_queue
	import rslc_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  rslc_work_t  wdata,
	input  logic        pop,
	output rslc_work_t  rdata,
	output rslc_qstat_t qstat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	rslc_work_t       entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign qstat.full  = (count_q == CNT_W'(DEPTH));
	assign qstat.empty = (count_q == '0);
	assign rdata       = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

`ifndef ASSERT_OFF
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && qstat.full))
		else $error("queue written while full");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && qstat.empty))
		else $error("queue read while empty");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count beyond depth");
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("queue count missed a write");
`endif

endmodule

@@ src/rslc_div_pipe.sv @@
// pipelined restoring divider, STEP_BITS quotient bits per stage
// quotient of {hi, lo} / div with hi < div; depends on rslc_pkg
module rslc_div_pipe
	import rslc_pkg::*;
#(
	parameter int DW = CH_W
) (
	input  logic             clk,
	input  logic             adv,
	input  logic [DW-1:0]    hi,
	input  logic [OUT_W-1:0] lo,
	input  logic [DW-1:0]    div,
	output logic [OUT_W-1:0] quot
);

	localparam int NST = DIV_STAGES;

	logic [DW-1:0]    rem_s  [NST];
	logic [OUT_W-1:0] lo_s   [NST];
	logic [DW-1:0]    div_s  [NST];
	logic [OUT_W-1:0] quot_s [NST];

	assign quot = quot_s[NST-1];

	genvar i;
	for (i = 0; i < NST; i++) begin : g_stage
		logic [DW-1:0]    rem_in;
		logic [OUT_W-1:0] lo_in;
		logic [DW-1:0]    div_in;
		logic [OUT_W-1:0] quot_in;
		logic [DW-1:0]    rem_nx;
		logic [OUT_W-1:0] lo_nx;
		logic [OUT_W-1:0] quot_nx;

		if (i == 0) begin : g_first
			assign rem_in  = hi;
			assign lo_in   = lo;
			assign div_in  = div;
			assign quot_in = '0;
		end else begin : g_next
			assign rem_in  = rem_s[i-1];
			assign lo_in   = lo_s[i-1];
			assign div_in  = div_s[i-1];
			assign quot_in = quot_s[i-1];
		end

		always_comb begin
			logic [DW:0] wide;
			rem_nx  = rem_in;
			lo_nx   = lo_in;
			quot_nx = quot_in;
			for (int k = 0; k < STEP_BITS; k++) begin
				wide  = {rem_nx, lo_nx[OUT_W-1]};
				lo_nx = {lo_nx[OUT_W-2:0], 1'b0};
				if (wide >= {1'b0, div_in}) begin
					rem_nx  = DW'(wide - {1'b0, div_in});
					quot_nx = {quot_nx[OUT_W-2:0], 1'b1};
				end else begin
					rem_nx  = wide[DW-1:0];
					quot_nx = {quot_nx[OUT_W-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				quot_s[i] <= quot_nx;
			end
		end

		// the last stage keeps only its quotient
		if (i < NST - 1) begin : g_keep
			always_ff @(posedge clk) begin
				if (adv) begin
					rem_s[i] <= rem_nx;
					lo_s[i]  <= lo_nx;
					div_s[i] <= div_in;
				end
			end
		end else begin : g_tail
			assign rem_s[i] = '0;
			assign lo_s[i]  = '0;
			assign div_s[i] = '0;
		end
	end

endmodule

@@ src/rslc_back.sv @@
// back end: hue and saturation dividers, lightness delay and output stage
// depends on rslc_pkg, rslc_div_pipe and rslc_hsl_if
module rslc_back
	import rslc_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  rslc_qstat_t  qstat,
	input  rslc_work_t   qdata,
	output logic         pop,
	rslc_hsl_if.source   color
);

	localparam int NST = DIV_STAGES;

	logic [NST-1:0]   v_s;
	logic [OUT_W-1:0] light_s [NST];
	logic             adv;

	// whole pipeline holds while the last stage waits for a transfer
	assign adv = !v_s[NST-1] || color.ready;
	assign pop = adv && !qstat.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (adv) begin
			v_s <= {v_s[NST-2:0], pop};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			light_s[0] <= qdata.lightness;
			for (int k = 1; k < NST; k++) begin
				light_s[k] <= light_s[k-1];
			end
		end
	end

	rslc_div_pipe #(
		.DW (HUE_W)
	) u_hue_div (
		.clk  (clk),
		.adv  (adv),
		.hi   (qdata.hue_num),
		.lo   (OUT_W'(0)),
		.div  (qdata.hue_div),
		.quot (color.hue)
	);

	rslc_div_pipe #(
		.DW (CH_W)
	) u_sat_div (
		.clk  (clk),
		.adv  (adv),
		.hi   (qdata.sat_hi),
		.lo   (qdata.sat_lo),
		.div  (qdata.sat_div),
		.quot (color.saturation)
	);

	assign color.valid     = v_s[NST-1];
	assign color.lightness = light_s[NST-1];

`ifndef ASSERT_OFF
	a_pop_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(pop) |=> v_s[0])
		else $error("popped item did not enter the divider");
	a_stall_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		(color.valid && !color.ready) |-> !pop)
		else $error("queue popped while output stalled");
	a_stall_keep: assert property (@(posedge clk) disable iff (!arst_n)
		(color.valid && !color.ready) |=> $stable(v_s))
		else $error("pipeline moved during a stall");
`endif

endmodule

@@ src/rgb_to_hsl_converter.sv @@
// top level of the rgb to hsl converter: front end, queue and divider back end
// depends on rslc_pkg, rslc_pixel_if, rslc_hsl_if, rslc_front, rslc_queue, rslc_back
//
//  channel | dir | payload                          | modport
//  --------+-----+----------------------------------+---------
//  pixel   | in  | red, green, blue (8 bit each)     | sink
//  color   | out | hue, saturation, lightness (16)   | source
//
// one pixel per clock sustained while color.ready is high; a pixel goes through
// the queue and then the two 16-bit divider pipelines, 4 quotient bits per stage
// reset clears queue pointers and stage valids; no clearing pass is needed
// a stalled output freezes the divider pipeline; the queue takes up to QUEUE_DEPTH
// further pixels before pixel.ready falls
module rgb_to_hsl_converter
	import rslc_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	rslc_pixel_if.sink pixel,
	rslc_hsl_if.source color
);

	rslc_qstat_t qstat;
	rslc_work_t  wdata;
	rslc_work_t  rdata;
	logic        push;
	logic        pop;

	rslc_front u_front (
		.pixel (pixel),
		.qstat (qstat),
		.push  (push),
		.work  (wdata)
	);

	rslc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (wdata),
		.pop    (pop),
		.rdata  (rdata),
		.qstat  (qstat)
	);

	rslc_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.qstat  (qstat),
		.qdata  (rdata),
		.pop    (pop),
		.color  (color)
	);

endmodule

@@ bench/rgb_to_hsl_converter_tb.sv @@
// self-checking bench for rgb_to_hsl_converter: corner pixels, random pixels, full-rate stream
// depends on rslc_pkg, rslc_pixel_if, rslc_hsl_if and the converter rtl
module rgb_to_hsl_converter_tb;
	import rslc_pkg::*;

	localparam int HANG_LIMIT    = 2000;
	localparam int SETTLE_CYCLES = 4 * (1 + DIV_STAGES);
	localparam int RANDOM_PIXELS = 380;
	localparam int STREAM_PIXELS = 100;

	typedef struct packed {
		logic [OUT_W-1:0] hue;
		logic [OUT_W-1:0] saturation;
		logic [OUT_W-1:0] lightness;
	} hsl_t;

	logic clk;
	logic arst_n;

	rslc_pixel_if pixel ();
	rslc_hsl_if   color ();

	rgb_to_hsl_converter dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pixel  (pixel),
		.color  (color)
	);

	hsl_t expected_hsl[$];
	int   mismatches     = 0;
	int   pixels_sent    = 0;
	int   colours_seen   = 0;
	int   grey_pixels    = 0;
	int   quiet_cycles   = 0;
	bit   full_rate      = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// exact fixed-point hsl of one pixel, red wins ties, then green
	function automatic hsl_t predict_hsl(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
		input logic [CH_W-1:0] b);
		int unsigned       hi;
		int unsigned       lo;
		int unsigned       d;
		int unsigned       sum;
		int unsigned       den;
		int unsigned       num;
		longint unsigned   q;
		rslc_maxsel_t      sel;
		hsl_t              res;

		if (r >= g && r >= b) begin
			sel = MAX_RED;
			hi  = r;
		end else if (g >= b) begin
			sel = MAX_GREEN;
			hi  = g;
		end else begin
			sel = MAX_BLUE;
			hi  = b;
		end
		lo = r;
		if (g < lo) lo = g;
		if (b < lo) lo = b;
		d   = hi - lo;
		sum = hi + lo;

		q = (longint'(sum) * 65535) / 510;
		res.lightness  = q[OUT_W-1:0];
		res.hue        = '0;
		res.saturation = '0;

		if (d != 0) begin
			den = (sum <= CH_MAX) ? sum : (2 * CH_MAX - sum);
			q = (longint'(d) * 65535) / den;
			res.saturation = q[OUT_W-1:0];
			case (sel)
				MAX_RED:   num = (g < b) ? 6 * d - (b - g) : g - b;
				MAX_GREEN: num = 2 * d + b - r;
				default:   num = 4 * d + r - g;
			endcase
			q = (longint'(num) * 65536) / (6 * longint'(d));
			res.hue = q[OUT_W-1:0];
		end
		return res;
	endfunction

	// sometimes a random gap before the pixel, never at full rate; then hold it until the transfer
	task automatic send_pixel(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
		input logic [CH_W-1:0] b);
		if (!full_rate && $urandom_range(0, 4) == 0) begin
			pixel.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		pixel.valid <= 1'b1;
		pixel.red   <= r;
		pixel.green <= g;
		pixel.blue  <= b;
		do @(posedge clk); while (!pixel.ready);
		expected_hsl.push_back(predict_hsl(r, g, b));
		pixels_sent++;
		if (r == g && g == b) grey_pixels++;
	endtask

	task automatic wait_drained();
		pixel.valid <= 1'b0;
		do @(posedge clk); while (expected_hsl.size() != 0);
	endtask

	task automatic test_corner_pixels();
		send_pixel(8'd0,   8'd0,   8'd0);
		send_pixel(8'd255, 8'd255, 8'd255);
		send_pixel(8'd128, 8'd128, 8'd128);
		send_pixel(8'd255, 8'd0,   8'd0);
		send_pixel(8'd0,   8'd255, 8'd0);
		send_pixel(8'd0,   8'd0,   8'd255);
		send_pixel(8'd255, 8'd255, 8'd0);
		send_pixel(8'd0,   8'd255, 8'd255);
		send_pixel(8'd255, 8'd0,   8'd255);
		// ties on the maximum
		send_pixel(8'd200, 8'd200, 8'd50);
		send_pixel(8'd50,  8'd200, 8'd200);
		send_pixel(8'd200, 8'd50,  8'd200);
		// red on top with blue above green wraps the hue, then single-step differences
		send_pixel(8'd255, 8'd0,   8'd1);
		send_pixel(8'd1,   8'd0,   8'd0);
		send_pixel(8'd0,   8'd1,   8'd1);
		send_pixel(8'd255, 8'd254, 8'd254);
		// lightness either side of one half
		send_pixel(8'd128, 8'd127, 8'd127);
		send_pixel(8'd129, 8'd127, 8'd127);
		send_pixel(8'd170, 8'd85,  8'd0);
		send_pixel(8'd85,  8'd170, 8'd255);
	endtask

	task automatic test_random_pixels(input int count);
		logic [CH_W-1:0] r;
		logic [CH_W-1:0] g;
		logic [CH_W-1:0] b;
		logic [CH_W-1:0] top;
		logic [CH_W-1:0] odd;

		repeat (count) begin
			r = CH_W'($urandom);
			g = CH_W'($urandom);
			b = CH_W'($urandom);
			case ($urandom_range(0, 7))
				0: begin
					g = r;
					b = r;
				end
				1: begin
					top = CH_W'($urandom);
					odd = CH_W'($urandom_range(0, top));
					case ($urandom_range(0, 2))
						0: {r, g, b} = {odd, top, top};
						1: {r, g, b} = {top, odd, top};
						default: {r, g, b} = {top, top, odd};
					endcase
				end
				2: begin
					// channels at most two steps apart
					g = (r > 8'd253) ? CH_W'(r - $urandom_range(0, 2))
						: CH_W'(r + $urandom_range(0, 2));
					b = (r > 8'd253) ? CH_W'(r - $urandom_range(0, 2))
						: CH_W'(r + $urandom_range(0, 2));
				end
				default: ;
			endcase
			send_pixel(r, g, b);
		end
	endtask

	task automatic test_pause_until_drained();
		test_random_pixels(8);
		wait_drained();
		test_random_pixels(8);
	endtask

	task automatic test_full_rate_stream(input int count);
		full_rate = 1'b1;
		test_random_pixels(count);
	endtask

	// output side stalls in bursts until the full-rate part
	initial begin : sink_stalls
		int stall_left;

		stall_left = 0;
		color.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				stall_left--;
				color.ready <= 1'b0;
			end else if (!full_rate && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 12) - 1;
				color.ready <= 1'b0;
			end else begin
				color.ready <= 1'b1;
			end
		end
	end

	function automatic void check_field(input string name, input logic [OUT_W-1:0] want,
		input logic [OUT_W-1:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endfunction

	always @(posedge clk) begin : colour_check
		hsl_t want;

		if (arst_n && color.valid && color.ready) begin
			colours_seen++;
			if (expected_hsl.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected transfer, expected none, actual hue %0d sat %0d light %0d",
					$time, color.hue, color.saturation, color.lightness);
			end else begin
				want = expected_hsl.pop_front();
				check_field("hue", want.hue, color.hue);
				check_field("saturation", want.saturation, color.saturation);
				check_field("lightness", want.lightness, color.lightness);
			end
		end
	end

	// ends a hung run: no transfer on either channel for too long
	always @(posedge clk) begin : hang_watch
		if (arst_n) begin
			if ((pixel.valid && pixel.ready) || (color.valid && color.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= HANG_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, HANG_LIMIT);
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	initial begin : main_sequence
		arst_n      = 1'b0;
		pixel.valid <= 1'b0;
		pixel.red   <= '0;
		pixel.green <= '0;
		pixel.blue  <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_corner_pixels();
		test_random_pixels(RANDOM_PIXELS / 2);
		test_pause_until_drained();
		test_random_pixels(RANDOM_PIXELS / 2);
		test_full_rate_stream(STREAM_PIXELS);

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_hsl.size() != 0) begin
			mismatches++;
			$display("%0t: %0d results never arrived", $time, expected_hsl.size());
		end

		$display("covered %0d pixels (%0d grey), %0d colours checked, %0d mismatches",
			pixels_sent, grey_pixels, colours_seen, mismatches);
		$display("corner pixels, ties, random and full-rate streams with stalls on both sides");
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
